@@ rtl/gn3d_pkg.sv @@
// Package: shared constants, permutation table and fixed-point helpers for gradient noise.
`default_nettype none
package gn3d_pkg;
  localparam int FracBits = 16;
  localparam int OutFracBits = 14;
  localparam int OneQ16 = 65536;

  function automatic logic [7:0] perm(input logic [7:0] i);
    logic [7:0] r;
    case (i)
      8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91; 8'd4: r=8'd90;
      8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13; 8'd8: r=8'd201; 8'd9: r=8'd95;
      8'd10: r=8'd96; 8'd11: r=8'd53; 8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7;
      8'd15: r=8'd225; 8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
      8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99; 8'd24: r=8'd37;
      8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10; 8'd28: r=8'd23; 8'd29: r=8'd190;
      8'd30: r=8'd6; 8'd31: r=8'd148; 8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234;
      8'd35: r=8'd75; 8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
      8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203; 8'd44: r=8'd117;
      8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32; 8'd48: r=8'd57; 8'd49: r=8'd177;
      8'd50: r=8'd33; 8'd51: r=8'd88; 8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56;
      8'd55: r=8'd87; 8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
      8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175; 8'd64: r=8'd74;
      8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134; 8'd68: r=8'd139; 8'd69: r=8'd48;
      8'd70: r=8'd27; 8'd71: r=8'd166; 8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158;
      8'd75: r=8'd231; 8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
      8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230; 8'd84: r=8'd220;
      8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41; 8'd88: r=8'd55; 8'd89: r=8'd46;
      8'd90: r=8'd245; 8'd91: r=8'd40; 8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143;
      8'd95: r=8'd54; 8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
      8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73; 8'd104: r=8'd209;
      8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187; 8'd108: r=8'd208; 8'd109: r=8'd89;
      8'd110: r=8'd18; 8'd111: r=8'd169; 8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135;
      8'd115: r=8'd130; 8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
      8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198; 8'd124: r=8'd173;
      8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64; 8'd128: r=8'd52; 8'd129: r=8'd217;
      8'd130: r=8'd226; 8'd131: r=8'd250; 8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5;
      8'd135: r=8'd202; 8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
      8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212; 8'd144: r=8'd207;
      8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227; 8'd148: r=8'd47; 8'd149: r=8'd16;
      8'd150: r=8'd58; 8'd151: r=8'd17; 8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28;
      8'd155: r=8'd42; 8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
      8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2; 8'd164: r=8'd44;
      8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70; 8'd168: r=8'd221; 8'd169: r=8'd153;
      8'd170: r=8'd101; 8'd171: r=8'd155; 8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172;
      8'd175: r=8'd9; 8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
      8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110; 8'd184: r=8'd79;
      8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232; 8'd188: r=8'd178; 8'd189: r=8'd185;
      8'd190: r=8'd112; 8'd191: r=8'd104; 8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97;
      8'd195: r=8'd228; 8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
      8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12; 8'd204: r=8'd191;
      8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241; 8'd208: r=8'd81; 8'd209: r=8'd51;
      8'd210: r=8'd145; 8'd211: r=8'd235; 8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239;
      8'd215: r=8'd107; 8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
      8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157; 8'd224: r=8'd184;
      8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176; 8'd228: r=8'd115; 8'd229: r=8'd121;
      8'd230: r=8'd50; 8'd231: r=8'd45; 8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150;
      8'd235: r=8'd254; 8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
      8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29; 8'd244: r=8'd24;
      8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141; 8'd248: r=8'd128; 8'd249: r=8'd195;
      8'd250: r=8'd78; 8'd251: r=8'd66; 8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156;
      default: r=8'd180;
    endcase
    return r;
  endfunction

  // Gradient dot product; offsets are Q16 in [-65536, 65535], result fits 19 bits.
  function automatic logic signed [18:0] grad(input logic [3:0] h,
      input logic signed [17:0] x, input logic signed [17:0] y,
      input logic signed [17:0] z);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    v = (h < 4'd4) ? 19'(y) : ((h == 4'd12 || h == 4'd14) ? 19'(x) : 19'(z));
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction
endpackage
`default_nettype wire

@@ rtl/gn3d_fade.sv @@
// Quintic fade curve pipeline: four register stages, Q0.16 in and out.
`default_nettype none
module gn3d_fade
  import gn3d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [16:0] t_in,
  output logic      [16:0] fade_out
);
  // t < 65536 so every product fits well under 64 bits and is non-negative
  // except the poly term, which is signed.
  logic [16:0] t1_r;
  logic [33:0] tt_r;
  logic signed [37:0] tp_r;
  logic [33:0] t3p_r;
  logic signed [20:0] poly_r;
  logic [16:0] t3_r;
  logic signed [20:0] pl;
  logic signed [54:0] fprod;
  logic signed [54:0] fsh;

  // 6t - 15.0 spans about -983040..-589830, needs 21 signed bits
  assign pl = 21'(signed'({4'b0, t1_r})) * 21'sd6 - 21'sd983040;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t_in;
      tt_r  <= 34'(t_in) * 34'(t_in);
      t3p_r <= 34'(tt_r[33:16]) * 34'(t1_r);
      tp_r  <= 38'(signed'({1'b0, t1_r})) * 38'(pl);
      t3_r  <= t3p_r[32:16];
      poly_r <= 21'(tp_r >>> 16) + 21'sd655360;
      fade_out <= fsh[16:0];
    end
  end

  assign fprod = 55'(signed'({1'b0, t3_r})) * 55'(poly_r);
  assign fsh = fprod >>> 16;
endmodule
`default_nettype wire

@@ rtl/gn3d_lerp.sv @@
// Registered lerp: a + floor(t * (b - a) / 2^16).
`default_nettype none
module gn3d_lerp
  import gn3d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [16:0] t,
  input  wire logic signed [20:0] a,
  input  wire logic signed [20:0] b,
  output logic      signed [20:0] y
);
  logic signed [21:0] d;
  logic signed [39:0] p;
  assign d = 22'(b) - 22'(a);
  assign p = 40'(signed'({1'b0, t})) * 40'(d);
  always_ff @(posedge clk) begin
    if (en) y <= 21'(22'(a) + 22'(p >>> 16));
  end
endmodule
`default_nettype wire

@@ rtl/gradient_noise_3d_top.sv @@
// Top level of the 3D gradient noise block.
// 3D gradient noise (quintic fade, 12 gradients) over a 256-entry hash table.
// Channels: in_valid/in_stall carry one point (in_coord_x/y/z, signed Q16.16);
// out_valid/out_stall carry one result (out_noise_value, signed Q1.14, saturated).
// An item is taken at an edge where valid is high and stall is low.
// cfg_we/cfg_wdata write seed_offset; write only while the block is idle.
// Throughput: one item per cycle while out_stall does not hold the pipeline. The
// result passes eight register stages, the first loaded at the accepting edge.
// The datapath is a fixed pipeline: cell split, three chained hash lookups,
// four fade register stages overlapped with them, gradients, then three lerp
// levels. The whole pipeline advances together; a stalled result holds every
// stage (in_stall = out_valid & out_stall), so nothing is lost or repeated.
// The permutation table is a constant ROM read at each hash stage.
// Reset (rst_n low, synchronous) clears all valid bits and seed_offset to 0.
// The block keeps no state between items.
`default_nettype none
module gradient_noise_3d_top
  import gn3d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_noise_value,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  localparam int Depth = 8;

  logic [7:0] seed_r;
  logic [Depth-1:0] vld_r;
  logic en;

  // whole pipe moves unless the finished item is held
  assign en = !(vld_r[Depth-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      vld_r  <= '0;
    end else begin
      if (cfg_we) seed_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // Stage 1: cells and fractions
  logic [7:0] cx1_r, cy1_r, cz1_r;
  logic [15:0] fx1_r, fy1_r, fz1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cx1_r <= in_coord_x[23:16] + seed_r;
      cy1_r <= in_coord_y[23:16] + seed_r;
      cz1_r <= in_coord_z[23:16] - seed_r;
      fx1_r <= in_coord_x[15:0];
      fy1_r <= in_coord_y[15:0];
      fz1_r <= in_coord_z[15:0];
    end
  end

  // Stage 2: a, b
  logic [7:0] a2_r, b2_r, cz2_r;
  logic [15:0] fx2_r, fy2_r, fz2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= perm(cx1_r) + cy1_r;
      b2_r <= perm(cx1_r + 8'd1) + cy1_r;
      cz2_r <= cz1_r;
      fx2_r <= fx1_r; fy2_r <= fy1_r; fz2_r <= fz1_r;
    end
  end

  // Stage 3: aa, ba, ab, bb
  logic [7:0] h3_r [4];
  logic [15:0] fx3_r, fy3_r, fz3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      h3_r[0] <= perm(a2_r) + cz2_r;
      h3_r[1] <= perm(b2_r) + cz2_r;
      h3_r[2] <= perm(a2_r + 8'd1) + cz2_r;
      h3_r[3] <= perm(b2_r + 8'd1) + cz2_r;
      fx3_r <= fx2_r; fy3_r <= fy2_r; fz3_r <= fz2_r;
    end
  end

  // Stage 4: gradient hashes, corner order idx = x + 2y + 4z
  logic [3:0] g4_r [8];
  logic [15:0] fx4_r, fy4_r, fz4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        g4_r[i]   <= 4'(perm(h3_r[i]));
        g4_r[i+4] <= 4'(perm(h3_r[i] + 8'd1));
      end
      fx4_r <= fx3_r; fy4_r <= fy3_r; fz4_r <= fz3_r;
    end
  end

  // Stage 5: corner gradients
  logic signed [20:0] gr5_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        gr5_r[i] <= 21'(grad(g4_r[i],
          i[0] ? 18'(signed'({2'b0, fx4_r})) - 18'sd65536 : 18'(signed'({2'b0, fx4_r})),
          i[1] ? 18'(signed'({2'b0, fy4_r})) - 18'sd65536 : 18'(signed'({2'b0, fy4_r})),
          i[2] ? 18'(signed'({2'b0, fz4_r})) - 18'sd65536 : 18'(signed'({2'b0, fz4_r}))));
      end
    end
  end

  // Fades: start at stage 1 outputs, ready after 4 more stages (aligned to stage 5)
  logic [16:0] u5, v5, w5;
  gn3d_fade u_fx (.clk, .en, .t_in({1'b0, fx1_r}), .fade_out(u5));
  gn3d_fade u_fy (.clk, .en, .t_in({1'b0, fy1_r}), .fade_out(v5));
  gn3d_fade u_fz (.clk, .en, .t_in({1'b0, fz1_r}), .fade_out(w5));

  logic [16:0] v6_r, w6_r, w7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      v6_r <= v5; w6_r <= w5; w7_r <= w6_r;
    end
  end

  // Stage 6: x lerps
  logic signed [20:0] lx [4];
  for (genvar k = 0; k < 4; k++) begin : g_lx
    gn3d_lerp u_l (.clk, .en, .t(u5), .a(gr5_r[2*k]), .b(gr5_r[2*k+1]), .y(lx[k]));
  end
  // Stage 7: y lerps
  logic signed [20:0] ly [2];
  for (genvar k = 0; k < 2; k++) begin : g_ly
    gn3d_lerp u_l (.clk, .en, .t(v6_r), .a(lx[2*k]), .b(lx[2*k+1]), .y(ly[k]));
  end
  // Stage 8: z lerp
  logic signed [20:0] lz;
  gn3d_lerp u_lz (.clk, .en, .t(w7_r), .a(ly[0]), .b(ly[1]), .y(lz));

  // Output scaling and saturation
  logic signed [18:0] sh;
  assign sh = 19'(lz >>> (FracBits - OutFracBits));
  assign out_noise_value = (sh > 19'sd32767) ? 16'sh7FFF :
                           (sh < -19'sd32768) ? 16'sh8000 : sh[15:0];

  // Assertions
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("stall without held result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("held result dropped");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall && !out_valid) |=> vld_r[0])
    else $error("accepted item lost");
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the 3D gradient noise block: directed and random points vs. a fixed-point predictor.
`default_nettype none
module tb_top
  import gn3d_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_noise_value;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  gradient_noise_3d_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_noise_value(out_noise_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int PipeLatency = 8;
  localparam int RandItems = 1150;

  // Seed copy held by the predictor; tracks every register write.
  logic [7:0] seed_shadow = '0;
  logic signed [15:0] noise_q[$];
  int errors = 0;
  int n_out = 0;
  int n_in = 0;
  int n_sat = 0;
  logic rx_idle_on = 1'b1;
  logic tx_idle_on = 1'b1;
  logic hold_off = 1'b0;

  // Floor division by 2^16 of a 64-bit signed value (>>> is a floor already).
  function automatic longint fl16(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint fade_q16(input longint t);
    longint t3, poly;
    t3 = fl16(fl16(t * t) * t);
    poly = fl16(t * (6 * t - 15 * 65536)) + 10 * 65536;
    return fl16(t3 * poly);
  endfunction

  function automatic longint mix_q16(input longint t, input longint a, input longint b);
    return a + fl16(t * (b - a));
  endfunction

  // Corner gradient dot product, one of 12 directions picked by the low hash nibble.
  function automatic longint corner_dot(input logic [7:0] hv, input longint x,
      input longint y, input longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [15:0] noise_at(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz, input logic [7:0] sd);
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    longint fx, fy, fz, gx, gy, gz, u, v, w, r;
    // Cell = floor(coord), low 8 bits only; the seed wraps the same way.
    cx = px[23:16] + sd;
    cy = py[23:16] + sd;
    cz = pz[23:16] - sd;
    fx = longint'(px[15:0]);
    fy = longint'(py[15:0]);
    fz = longint'(pz[15:0]);
    gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
    u = fade_q16(fx); v = fade_q16(fy); w = fade_q16(fz);
    a = perm(cx) + cy;
    aa = perm(a) + cz;
    ab = perm(a + 8'd1) + cz;
    b = perm(cx + 8'd1) + cy;
    ba = perm(b) + cz;
    bb = perm(b + 8'd1) + cz;
    r = mix_q16(w,
          mix_q16(v,
            mix_q16(u, corner_dot(perm(aa), fx, fy, fz), corner_dot(perm(ba), gx, fy, fz)),
            mix_q16(u, corner_dot(perm(ab), fx, gy, fz), corner_dot(perm(bb), gx, gy, fz))),
          mix_q16(v,
            mix_q16(u, corner_dot(perm(aa + 8'd1), fx, fy, gz),
                       corner_dot(perm(ba + 8'd1), gx, fy, gz)),
            mix_q16(u, corner_dot(perm(ab + 8'd1), fx, gy, gz),
                       corner_dot(perm(bb + 8'd1), gx, gy, gz))));
    r = r >>> 2;  // Q16 down to Q14
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Directed table: coordinates plus an optional typed-in expectation.
  typedef struct {
    logic signed [31:0] x, y, z;
    logic has_exp;
    logic signed [15:0] exp_val;
  } point_row_t;

  point_row_t dir_tab[] = '{
    // integer lattice points: every fraction is zero, noise is exactly zero
    '{32'sh0, 32'sh0, 32'sh0, 1'b1, 16'sd0},
    '{32'sh0005_0000, -32'sh0003_0000, 32'sh00FF_0000, 1'b1, 16'sd0},
    '{32'sh7FFF_0000, 32'sh8000_0000, 32'sh7FFF_0000, 1'b1, 16'sd0},
    // extremes of the fields
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'sd0},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 16'sd0},
    '{-32'sh1, -32'sh1, -32'sh1, 1'b0, 16'sd0},
    '{32'sh1, 32'sh1, 32'sh1, 1'b0, 16'sd0},
    '{32'sh8000_FFFF, 32'sh7FFF_0001, 32'sh0000_8000, 1'b0, 16'sd0},
    // cell wrap across 255 -> 0 and negative cells
    '{32'sh00FF_8000, 32'sh00FF_8000, 32'sh00FF_8000, 1'b0, 16'sd0},
    '{32'sh0100_8000, 32'sh0100_8000, 32'sh0100_8000, 1'b0, 16'sd0},
    '{-32'sh0000_8000, -32'sh0001_4000, -32'sh00FF_C000, 1'b0, 16'sd0},
    // mid-cell, near-corner and arbitrary points
    '{32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0},
    '{32'sh0000_FFFF, 32'sh0000_0001, 32'sh0000_FFFF, 1'b0, 16'sd0},
    '{32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, 1'b0, 16'sd0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_AAAA, 1'b0, 16'sd0}
  };

  // Send one point; waits for the handshake. Idles before it at random.
  // in_valid stays high after the handshake; the next call or the caller drops it.
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    while (tx_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= px; in_coord_y <= py; in_coord_z <= pz;
    noise_q.push_back(noise_at(px, py, pz, seed_shadow));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_in++;
    @(negedge clk);
  endtask

  // Wait for the block to drain, then write the seed.
  task automatic write_seed(input logic [7:0] sd);
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(negedge clk);
    repeat (PipeLatency + 2) @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= sd;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_shadow = sd;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();                                   // anywhere
      1: return {{8{1'b0}}, 8'($urandom), 16'($urandom)};     // small positive
      2: return -{{8{1'b0}}, 8'($urandom), 16'($urandom)};    // small negative
      default: return {16'($urandom), 16'($urandom_range(1) ? 16'hFFFF : 16'h0001)};
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off to back the pipe up.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= rx_idle_on && ($urandom_range(99) < 36);
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        $error("noise_value: result with no expectation, actual %0d", out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== noise_q[0]) begin
          $error("noise_value: expected %0d actual %0d", noise_q[0], out_noise_value);
          errors++;
        end
        if (noise_q[0] == 16'sh7FFF || noise_q[0] == -16'sh8000) n_sat++;
        void'(noise_q.pop_front());
      end
      n_out++;
    end
  end

  // Long hold-off counted in its own process.
  initial begin
    @(posedge rst_n);
    repeat (300) @(negedge clk);
    hold_off = 1'b1;
    repeat (60) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [7:0] seeds[5];
    seeds = '{8'd0, 8'd255, 8'd1, 8'h80, 8'h5A};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table at reset seed, then again at max seed.
    for (int p = 0; p < 2; p++) begin
      if (p == 1) write_seed(8'hFF);
      foreach (dir_tab[i]) begin
        send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z);
        if (dir_tab[i].has_exp && noise_q[$] !== dir_tab[i].exp_val) begin
          $error("noise_value: predictor expected %0d actual %0d",
                 dir_tab[i].exp_val, noise_q[$]);
          errors++;
        end
      end
    end

    // Random phases over several seeds; one phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      write_seed(ph == 4 ? 8'($urandom) : seeds[ph]);
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      for (int k = 0; k < RandItems / 5; k++)
        send_point(rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    while (noise_q.size() != 0) @(negedge clk);
    repeat (PipeLatency + 4) @(negedge clk);
    $display("Covered %0d points, %0d results (%0d saturated) over seven seed phases.",
             n_in, n_out, n_sat);
    if (errors == 0) $display("[gradient_noise_3d_top] OK");
    else $display("[gradient_noise_3d_top] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[gradient_noise_3d_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/gn3d_pkg.sv
rtl/gn3d_fade.sv
rtl/gn3d_lerp.sv
rtl/gradient_noise_3d_top.sv
dv/tb_top.sv
